FILE: rtl/mlfq_pkg.sv
package mlfq_pkg;

   localparam int NPROC  = 16;
   localparam int PID_W  = 5;
   localparam int IDX_W  = $clog2(NPROC);
   localparam int FILL_W = $clog2(NPROC + 1);
   localparam int NLEVEL = 3;

   localparam logic [2:0] ST_UNUSED   = 3'd0;
   localparam logic [2:0] ST_READY    = 3'd1;
   localparam logic [2:0] ST_RUNNING  = 3'd2;
   localparam logic [2:0] ST_RUNNABLE = 3'd3;
   localparam logic [2:0] ST_SLEEPING = 3'd4;
   localparam logic [2:0] ST_WAITING  = 3'd5;

   localparam logic [2:0] KIND_ARRIVE = 3'd0;
   localparam logic [2:0] KIND_YIELD  = 3'd1;
   localparam logic [2:0] KIND_STOP   = 3'd2;
   localparam logic [2:0] KIND_SLEEP  = 3'd3;
   localparam logic [2:0] KIND_SETST  = 3'd4;

   localparam logic [1:0] REG_QUANTUM = 2'd0;
   localparam logic [1:0] REG_SYSPID  = 2'd1;
   localparam logic [1:0] REG_MIDQ    = 2'd2;
   localparam logic [1:0] REG_LOWQ    = 2'd3;

   localparam logic [1:0] LV_HIGH = 2'd0;
   localparam logic [1:0] LV_MID  = 2'd1;
   localparam logic [1:0] LV_LOW  = 2'd2;

   typedef struct packed {
      logic             push;
      logic             drop;
      logic [IDX_W-1:0] pos;
      logic [PID_W-1:0] pid;
   } qcmd_type;

   typedef struct packed {
      logic             wr;
      logic             shift;
      logic [PID_W-1:0] wdata;
   } cell_ctl_type;

endpackage

FILE: rtl/mlfq_if.sv
interface mlfq_req_if;
   import mlfq_pkg::*;
   logic             valid;
   logic             ready;
   logic [2:0]       kind;
   logic [PID_W-1:0] pid;
   logic [63:0]      now;
   logic [15:0]      sleep_units;
   logic [2:0]       new_status;
   modport source (output valid, kind, pid, now, sleep_units, new_status, input ready);
   modport sink (input valid, kind, pid, now, sleep_units, new_status, output ready);
endinterface

interface mlfq_rsp_if;
   import mlfq_pkg::*;
   logic             valid;
   logic             ready;
   logic [PID_W-1:0] run_pid;
   logic             switched;
   logic             bad_pid;
   logic [63:0]      turnaround_ticks;
   logic [63:0]      response_ticks;
   logic [63:0]      cpu_ticks;
   logic [31:0]      yield_count;
   modport source (output valid, run_pid, switched, bad_pid, turnaround_ticks,
                   response_ticks, cpu_ticks, yield_count, input ready);
   modport sink (input valid, run_pid, switched, bad_pid, turnaround_ticks,
                 response_ticks, cpu_ticks, yield_count, output ready);
endinterface

FILE: rtl/mlfq_process_scheduler_core.sv
// channel   direction  transfer on             payload
// req_ch    in         req valid & ready       kind, pid, now, sleep_units, new_status
// rsp_ch    out        rsp valid & ready       run_pid, switched, bad_pid, metrics
// csr_*     in/out     psel&penable&pwrite     quantum, sys pid limit, level quanta
//
// arrive, set status, unknown kinds, bad pids and live stops go from DISPATCH to OUT_SET,
// sleep through SLP first; a stop on an unused process walks the queues in RM entry
// by entry until it finds the pid or passes the end of the low queue
// a yield adds cpu time in Y_ADD, scans the queues in SCAN and SCHK, requeues the
// current process in REQ and, if a process was found, switches in SW0 and SW1; it
// makes up to two scans of all three queues
// reset is synchronous; queue cells are not reset, only entries below the fill are read
// an event is taken while an earlier result still waits on rsp_ch, then holds in OUT
module mlfq_process_scheduler_core
   import mlfq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   mlfq_req_if.sink     req_ch,
   mlfq_rsp_if.source   rsp_ch,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int THR_W  = 40;
   localparam int SPAN_W = 48;

   typedef enum logic [3:0] {
      IDLE, DISPATCH, Y_ADD, SCAN, SCHK, SCAN_END, REQ, SW0, SW1,
      RM, SLP, OUT_SET, OUT
   } state_type;

   state_type state_ff;

   logic [31:0] quantum_ff;
   logic [4:0]  sys_ff;
   logic [7:0]  midq_ff;
   logic [7:0]  lowq_ff;

   logic [2:0]  status_mem  [NPROC];
   logic [63:0] cpu_mem     [NPROC];
   logic [63:0] arrival_mem [NPROC];
   logic [63:0] lastrun_mem [NPROC];
   logic [63:0] wake_mem    [NPROC];
   logic [63:0] resp_mem    [NPROC];
   logic [31:0] count_mem   [NPROC];

   logic [IDX_W-1:0]  cur_ff;
   logic [IDX_W-1:0]  pa_ff;
   logic              pending_ff;
   logic [2:0]        kind_ff;
   logic [PID_W-1:0]  pid_ff;
   logic              pid_ok_ff;
   logic [63:0]       now_ff;
   logic [15:0]       units_ff;
   logic [2:0]        nst_ff;
   logic [63:0]       diff_ff;
   logic [THR_W-1:0]  thr_mid_ff;
   logic [THR_W-1:0]  thr_low_ff;
   logic [SPAN_W-1:0] span_ff;
   logic [1:0]        lv_ff;
   logic [FILL_W-1:0] i_ff;
   logic              pass_ff;
   logic [PID_W-1:0]  nxt_ff;
   logic              sw_ff;
   logic              bad_ff;
   logic [63:0]       tat_ff;
   logic [63:0]       resp_ff;
   logic [63:0]       cpu_ff;
   logic [31:0]       cnt_ff;

   logic              rsp_valid_ff;
   logic [PID_W-1:0]  o_next_ff;
   logic              o_sw_ff;
   logic              o_bad_ff;
   logic [63:0]       o_tat_ff;
   logic [63:0]       o_resp_ff;
   logic [63:0]       o_cpu_ff;
   logic [31:0]       o_cnt_ff;

   qcmd_type          qcmd    [NLEVEL];
   logic [PID_W-1:0]  q_entry [NLEVEL];
   logic [FILL_W-1:0] q_fill  [NLEVEL];

   for (genvar l = 0; l < NLEVEL; l++) begin : g_lv
      mlfq_queue u_queue (
         .clock    (clock),
         .reset    (reset),
         .cmd      (qcmd[l]),
         .rd_idx   (i_ff[IDX_W-1:0]),
         .rd_entry (q_entry[l]),
         .fill     (q_fill[l])
      );
   end

   logic             csr_wr;
   logic             in_range;
   logic [PID_W-1:0] scan_p;
   logic             scan_p_ok;
   logic [2:0]       st_pa;
   logic             woke;
   logic             eligible;
   logic [1:0]       req_lv;
   logic             req_pid_ok;
   logic [64:0]      wake_sum;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign in_range   = i_ff < q_fill[lv_ff];
   assign scan_p     = q_entry[lv_ff];
   assign scan_p_ok  = (scan_p >= PID_W'(1)) && (scan_p <= PID_W'(NPROC));
   assign st_pa      = status_mem[pa_ff];
   assign woke       = (st_pa == ST_SLEEPING) && (wake_mem[pa_ff] <= now_ff);
   assign eligible   = woke || st_pa == ST_READY || st_pa == ST_RUNNING
                       || st_pa == ST_RUNNABLE;
   assign wake_sum   = 65'(now_ff) + 65'(span_ff);
   assign req_pid_ok = req_ch.pid >= PID_W'(1) && req_ch.pid <= PID_W'(NPROC);

   always_comb begin
      if ((PID_W + 1)'(cur_ff) + (PID_W + 1)'(1) < (PID_W + 1)'(sys_ff)) begin
         req_lv = LV_HIGH;
      end else if (cpu_mem[pa_ff] < 64'(thr_mid_ff)) begin
         req_lv = LV_HIGH;
      end else if (cpu_mem[pa_ff] < 64'(thr_low_ff)) begin
         req_lv = LV_MID;
      end else begin
         req_lv = LV_LOW;
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_QUANTUM: csr_prdata = quantum_ff;
         REG_SYSPID:  csr_prdata = 32'(sys_ff);
         REG_MIDQ:    csr_prdata = 32'(midq_ff);
         REG_LOWQ:    csr_prdata = 32'(lowq_ff);
         default:     csr_prdata = '0;
      endcase
   end

   always_comb begin
      for (int l = 0; l < NLEVEL; l++) begin
         qcmd[l] = '0;
      end
      case (state_ff)
         DISPATCH: begin
            if (kind_ff == KIND_ARRIVE && pid_ok_ff && !pending_ff) begin
               qcmd[LV_HIGH].push = 1'b1;
               qcmd[LV_HIGH].pid  = pid_ff;
            end
         end
         SCHK: begin
            if (eligible) begin
               qcmd[lv_ff].drop = 1'b1;
               qcmd[lv_ff].pos  = i_ff[IDX_W-1:0];
            end
         end
         REQ: begin
            if (st_pa != ST_UNUSED) begin
               qcmd[req_lv].push = 1'b1;
               qcmd[req_lv].pid  = PID_W'(cur_ff) + PID_W'(1);
            end
         end
         RM: begin
            if (in_range && scan_p == pid_ff) begin
               qcmd[lv_ff].drop = 1'b1;
               qcmd[lv_ff].pos  = i_ff[IDX_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         quantum_ff   <= 32'd1000;
         sys_ff       <= 5'd5;
         midq_ff      <= 8'd1;
         lowq_ff      <= 8'd2;
         cur_ff       <= '0;
         pa_ff        <= '0;
         pending_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NPROC; k++) begin
            status_mem[k]  <= ST_UNUSED;
            cpu_mem[k]     <= '0;
            arrival_mem[k] <= '0;
            lastrun_mem[k] <= '0;
            wake_mem[k]    <= '0;
            resp_mem[k]    <= '0;
            count_mem[k]   <= '0;
         end
      end else begin
         if (csr_wr) begin
            unique case (csr_paddr[3:2])
               REG_QUANTUM: quantum_ff <= csr_pwdata;
               REG_SYSPID:  sys_ff     <= csr_pwdata[4:0];
               REG_MIDQ:    midq_ff    <= csr_pwdata[7:0];
               REG_LOWQ:    lowq_ff    <= csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_ch.ready && state_ff != OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_ch.valid) begin
                  kind_ff   <= req_ch.kind;
                  pid_ff    <= req_ch.pid;
                  pid_ok_ff <= req_pid_ok;
                  now_ff    <= req_ch.now;
                  units_ff  <= req_ch.sleep_units;
                  nst_ff    <= req_ch.new_status;
                  sw_ff     <= 1'b0;
                  bad_ff    <= 1'b0;
                  tat_ff    <= '0;
                  resp_ff   <= '0;
                  cpu_ff    <= '0;
                  cnt_ff    <= '0;
                  nxt_ff    <= '0;
                  pass_ff   <= 1'b0;
                  lv_ff     <= LV_HIGH;
                  i_ff      <= '0;
                  if (req_ch.kind == KIND_YIELD || !req_pid_ok) begin
                     pa_ff <= cur_ff;
                  end else begin
                     pa_ff <= IDX_W'(req_ch.pid - PID_W'(1));
                  end
                  state_ff <= DISPATCH;
               end
            end
            DISPATCH: begin
               if (kind_ff == KIND_YIELD) begin
                  diff_ff    <= now_ff - lastrun_mem[pa_ff];
                  thr_mid_ff <= THR_W'(quantum_ff) * THR_W'(midq_ff);
                  thr_low_ff <= THR_W'(quantum_ff) * THR_W'(lowq_ff);
                  state_ff   <= Y_ADD;
               end else if (kind_ff <= KIND_SETST && !pid_ok_ff) begin
                  bad_ff   <= 1'b1;
                  state_ff <= OUT_SET;
               end else begin
                  case (kind_ff)
                     KIND_ARRIVE: begin
                        cpu_mem[pa_ff]     <= '0;
                        lastrun_mem[pa_ff] <= '0;
                        wake_mem[pa_ff]    <= '0;
                        resp_mem[pa_ff]    <= '0;
                        count_mem[pa_ff]   <= '0;
                        arrival_mem[pa_ff] <= now_ff;
                        status_mem[pa_ff]  <= ST_READY;
                        pending_ff         <= 1'b0;
                        state_ff           <= OUT_SET;
                     end
                     KIND_STOP: begin
                        if (st_pa == ST_UNUSED) begin
                           tat_ff   <= now_ff - arrival_mem[pa_ff];
                           resp_ff  <= resp_mem[pa_ff];
                           cpu_ff   <= cpu_mem[pa_ff];
                           cnt_ff   <= count_mem[pa_ff];
                           state_ff <= RM;
                        end else begin
                           state_ff <= OUT_SET;
                        end
                     end
                     KIND_SLEEP: begin
                        span_ff  <= SPAN_W'(units_ff) * SPAN_W'(quantum_ff);
                        state_ff <= SLP;
                     end
                     KIND_SETST: begin
                        if (nst_ff <= ST_WAITING) begin
                           status_mem[pa_ff] <= nst_ff;
                        end
                        state_ff <= OUT_SET;
                     end
                     default: state_ff <= OUT_SET;
                  endcase
               end
            end
            Y_ADD: begin
               cpu_mem[pa_ff] <= cpu_mem[pa_ff] + diff_ff;
               state_ff       <= SCAN;
            end
            SCAN: begin
               if (!in_range) begin
                  i_ff <= '0;
                  if (lv_ff == LV_LOW) begin
                     state_ff <= SCAN_END;
                  end else begin
                     lv_ff <= lv_ff + 2'd1;
                  end
               end else if (scan_p_ok) begin
                  pa_ff    <= IDX_W'(scan_p - PID_W'(1));
                  state_ff <= SCHK;
               end else begin
                  i_ff <= i_ff + FILL_W'(1);
               end
            end
            SCHK: begin
               if (woke) begin
                  status_mem[pa_ff] <= ST_RUNNABLE;
               end
               if (eligible) begin
                  nxt_ff   <= PID_W'(pa_ff) + PID_W'(1);
                  state_ff <= SCAN_END;
               end else begin
                  i_ff     <= i_ff + FILL_W'(1);
                  state_ff <= SCAN;
               end
            end
            SCAN_END: begin
               pa_ff    <= cur_ff;
               state_ff <= pass_ff ? SW0 : REQ;
            end
            REQ: begin
               pass_ff <= 1'b1;
               lv_ff   <= LV_HIGH;
               i_ff    <= '0;
               state_ff <= (nxt_ff != '0) ? SW0 : SCAN;
            end
            SW0: begin
               if (nxt_ff == '0) begin
                  state_ff <= OUT_SET;
               end else begin
                  if (st_pa == ST_RUNNING) begin
                     status_mem[pa_ff] <= ST_RUNNABLE;
                  end
                  pa_ff    <= IDX_W'(nxt_ff - PID_W'(1));
                  cur_ff   <= IDX_W'(nxt_ff - PID_W'(1));
                  sw_ff    <= 1'b1;
                  state_ff <= SW1;
               end
            end
            SW1: begin
               lastrun_mem[pa_ff] <= now_ff;
               if (count_mem[pa_ff] == '0) begin
                  resp_mem[pa_ff] <= now_ff - arrival_mem[pa_ff];
               end
               if (count_mem[pa_ff] != '1) begin
                  count_mem[pa_ff] <= count_mem[pa_ff] + 32'd1;
               end
               status_mem[pa_ff] <= ST_RUNNING;
               state_ff          <= OUT_SET;
            end
            RM: begin
               if (!in_range) begin
                  i_ff <= '0;
                  if (lv_ff == LV_LOW) begin
                     state_ff <= OUT_SET;
                  end else begin
                     lv_ff <= lv_ff + 2'd1;
                  end
               end else if (scan_p == pid_ff) begin
                  state_ff <= OUT_SET;
               end else begin
                  i_ff <= i_ff + FILL_W'(1);
               end
            end
            SLP: begin
               status_mem[pa_ff] <= ST_SLEEPING;
               wake_mem[pa_ff]   <= wake_sum[64] ? '1 : wake_sum[63:0];
               state_ff          <= OUT_SET;
            end
            OUT_SET: begin
               pa_ff    <= cur_ff;
               state_ff <= OUT;
            end
            OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  o_next_ff    <= (st_pa == ST_RUNNING) ? PID_W'(cur_ff) + PID_W'(1) : '0;
                  o_sw_ff      <= sw_ff;
                  o_bad_ff     <= bad_ff;
                  o_tat_ff     <= tat_ff;
                  o_resp_ff    <= resp_ff;
                  o_cpu_ff     <= cpu_ff;
                  o_cnt_ff     <= cnt_ff;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign req_ch.ready            = (state_ff == IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.run_pid          = o_next_ff;
   assign rsp_ch.switched         = o_sw_ff;
   assign rsp_ch.bad_pid          = o_bad_ff;
   assign rsp_ch.turnaround_ticks = o_tat_ff;
   assign rsp_ch.response_ticks   = o_resp_ff;
   assign rsp_ch.cpu_ticks        = o_cpu_ff;
   assign rsp_ch.yield_count      = o_cnt_ff;

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff != IDLE)
      else $error("event taken but sequencer stayed idle");

   a_cur_only_on_switch: assert property (@(posedge clock) disable iff (reset)
      cur_ff != $past(cur_ff) |-> $past(state_ff) == SW0)
      else $error("current process changed outside a switch");

   a_switch_has_pid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_sw_ff |-> o_next_ff != '0)
      else $error("switch reported with no running process");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      q_fill[0] <= FILL_W'(NPROC) && q_fill[1] <= FILL_W'(NPROC)
      && q_fill[2] <= FILL_W'(NPROC))
      else $error("queue fill beyond capacity");

endmodule

FILE: rtl/mlfq_qcell.sv
module mlfq_qcell
   import mlfq_pkg::*;
(
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [PID_W-1:0] neighbor,
   output logic [PID_W-1:0] entry
);

   logic [PID_W-1:0] entry_ff;
   logic [PID_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = neighbor;
      end else if (ctl.wr) begin
         entry_in = ctl.wdata;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/mlfq_queue.sv
module mlfq_queue
   import mlfq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  qcmd_type          cmd,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [PID_W-1:0]  rd_entry,
   output logic [FILL_W-1:0] fill
);

   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [PID_W-1:0]  entries [NPROC];
   logic              full;

   assign full = (fill_ff == FILL_W'(NPROC));

   for (genvar k = 0; k < NPROC; k++) begin : g_cell
      cell_ctl_type     ctl;
      logic [PID_W-1:0] nb;
      assign ctl.wr    = cmd.push && !full && (fill_ff == FILL_W'(k));
      assign ctl.shift = cmd.drop && (IDX_W'(k) >= cmd.pos)
                         && (FILL_W'(k) + FILL_W'(1) < fill_ff);
      assign ctl.wdata = cmd.pid;
      if (k + 1 < NPROC) begin : g_nb
         assign nb = entries[k + 1];
      end else begin : g_last
         assign nb = '0;
      end
      mlfq_qcell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .neighbor (nb),
         .entry    (entries[k])
      );
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.push && !full) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (cmd.drop) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign rd_entry = entries[rd_idx];
   assign fill     = fill_ff;

endmodule

FILE: verif/mlfq_checker.sv
`timescale 1ns / 100ps

module mlfq_checker
   import mlfq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mlfq_req_if         req,
   mlfq_rsp_if         rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [PID_W-1:0] run_pid;
      logic             switched;
      logic             bad_pid;
      logic [63:0]      turnaround;
      logic [63:0]      response;
      logic [63:0]      cpu;
      logic [31:0]      runs;
   } sched_result_type;

   sched_result_type expected_results[$];

   logic [31:0] quantum;
   logic [4:0]  sys_limit;
   logic [7:0]  mid_quanta;
   logic [7:0]  low_quanta;

   logic [2:0]  status [NPROC];
   logic [63:0] cpu_total [NPROC];
   logic [63:0] arrived_at [NPROC];
   logic [63:0] last_run [NPROC];
   logic [63:0] wake_at [NPROC];
   logic [63:0] first_resp [NPROC];
   logic [31:0] run_total [NPROC];
   int unsigned run_queue [NLEVEL][$];
   int unsigned cur_slot;
   logic        first_arrival;
   int          mismatches;

   function automatic void level_push(int lv, int unsigned p);
      if (run_queue[lv].size() < NPROC) run_queue[lv].push_back(p);
   endfunction

   function automatic bit level_remove(int lv, int unsigned p);
      foreach (run_queue[lv][i]) begin
         if (run_queue[lv][i] == p) begin
            run_queue[lv].delete(i);
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic int unsigned pick_runnable(logic [63:0] now);
      int unsigned p;
      for (int lv = 0; lv < NLEVEL; lv++) begin
         for (int i = 0; i < run_queue[lv].size(); i++) begin
            p = run_queue[lv][i];
            if (status[p-1] == ST_SLEEPING && wake_at[p-1] <= now) status[p-1] = ST_RUNNABLE;
            if (status[p-1] == ST_READY || status[p-1] == ST_RUNNING ||
                status[p-1] == ST_RUNNABLE) begin
               run_queue[lv].delete(i);
               return p;
            end
         end
      end
      return 0;
   endfunction

   function automatic sched_result_type schedule_event(logic [2:0] kind, logic [4:0] pid,
         logic [63:0] now, logic [15:0] units, logic [2:0] nst);
      sched_result_type r;
      int unsigned   cur, nxt, ix;
      logic [63:0]   q, wake;
      bit            pid_ok, found;
      r = '{default: '0};
      pid_ok = pid >= 1 && pid <= NPROC;
      ix = pid_ok ? pid - 1 : 0;
      if (kind == KIND_YIELD) begin
         cur = cur_slot;
         cpu_total[cur] += now - last_run[cur];
         nxt = pick_runnable(now);
         if (status[cur] != ST_UNUSED) begin
            q = {32'd0, quantum};
            if (cur + 1 < sys_limit) level_push(LV_HIGH, cur + 1);
            else if (cpu_total[cur] < q * mid_quanta) level_push(LV_HIGH, cur + 1);
            else if (cpu_total[cur] < q * low_quanta) level_push(LV_MID, cur + 1);
            else level_push(LV_LOW, cur + 1);
         end
         if (nxt == 0) nxt = pick_runnable(now);
         if (nxt != 0) begin
            if (status[cur] == ST_RUNNING) status[cur] = ST_RUNNABLE;
            cur_slot = nxt - 1;
            last_run[nxt-1] = now;
            if (run_total[nxt-1] == 0) first_resp[nxt-1] = now - arrived_at[nxt-1];
            if (run_total[nxt-1] != 32'hFFFF_FFFF) run_total[nxt-1]++;
            status[nxt-1] = ST_RUNNING;
            r.switched = 1;
         end
      end else if (kind <= KIND_SETST) begin
         if (!pid_ok) begin
            r.bad_pid = 1;
         end else if (kind == KIND_ARRIVE) begin
            cpu_total[ix] = 0;
            last_run[ix] = 0;
            wake_at[ix] = 0;
            first_resp[ix] = 0;
            run_total[ix] = 0;
            arrived_at[ix] = now;
            status[ix] = ST_READY;
            if (first_arrival) first_arrival = 0;
            else level_push(LV_HIGH, pid);
         end else if (kind == KIND_STOP) begin
            if (status[ix] == ST_UNUSED) begin
               r.turnaround = now - arrived_at[ix];
               r.response = first_resp[ix];
               r.cpu = cpu_total[ix];
               r.runs = run_total[ix];
               found = level_remove(LV_HIGH, pid);
               if (!found) found = level_remove(LV_MID, pid);
               if (!found) found = level_remove(LV_LOW, pid);
            end
         end else if (kind == KIND_SLEEP) begin
            wake = now + {48'd0, units} * {32'd0, quantum};
            if (wake < now) wake = '1;
            status[ix] = ST_SLEEPING;
            wake_at[ix] = wake;
         end else begin
            if (nst <= ST_WAITING) status[ix] = nst;
         end
      end
      r.run_pid = (status[cur_slot] == ST_RUNNING) ? PID_W'(cur_slot + 1) : '0;
      return r;
   endfunction

   always @(posedge clock) begin
      sched_result_type got, exp_r;
      if (reset) begin
         quantum = 1000;
         sys_limit = 5;
         mid_quanta = 1;
         low_quanta = 2;
         for (int i = 0; i < NPROC; i++) begin
            status[i] = ST_UNUSED;
            cpu_total[i] = 0;
            arrived_at[i] = 0;
            last_run[i] = 0;
            wake_at[i] = 0;
            first_resp[i] = 0;
            run_total[i] = 0;
         end
         for (int lv = 0; lv < NLEVEL; lv++) run_queue[lv].delete();
         cur_slot = 0;
         first_arrival = 1;
         expected_results.delete();
         fail_count = 0;
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_QUANTUM: quantum = csr_pwdata;
               REG_SYSPID:  sys_limit = csr_pwdata[4:0];
               REG_MIDQ:    mid_quanta = csr_pwdata[7:0];
               REG_LOWQ:    low_quanta = csr_pwdata[7:0];
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.run_pid, rsp.switched, rsp.bad_pid, rsp.turnaround_ticks,
                    rsp.response_ticks, rsp.cpu_ticks, rsp.yield_count};
            if (expected_results.size() == 0) begin
               fail_count++;
               mismatches++;
               if (mismatches <= 10) $display("%0t: result transfer with nothing expected", $realtime);
            end else begin
               exp_r = expected_results.pop_front();
               if (got !== exp_r) begin
                  fail_count++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch exp pid %0d sw %0b bad %0b tat %0d resp %0d cpu %0d n %0d",
                              $realtime, exp_r.run_pid, exp_r.switched, exp_r.bad_pid,
                              exp_r.turnaround, exp_r.response, exp_r.cpu, exp_r.runs,
                              "\n   got pid %0d sw %0b bad %0b tat %0d resp %0d cpu %0d n %0d",
                              got.run_pid, got.switched, got.bad_pid, got.turnaround,
                              got.response, got.cpu, got.runs);
               end
            end
         end
         if (req.valid && req.ready)
            expected_results.push_back(schedule_event(req.kind, req.pid, req.now,
                                                       req.sleep_units, req.new_status));
      end
      pending = expected_results.size();
   end

endmodule

FILE: verif/tb_mlfq_process_scheduler_core.sv
`timescale 1ns / 100ps

module tb_mlfq_process_scheduler_core;
   import mlfq_pkg::*;

   localparam logic [2:0] KIND_LAST = 3'd7;
   localparam logic [2:0] ST_LAST   = 3'd7;
   localparam int DRAIN_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, pending;
   bit          no_idle, hold_off;
   logic [63:0] clock_now;

   mlfq_req_if req_ch ();
   mlfq_rsp_if rsp_ch ();

   mlfq_process_scheduler_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   mlfq_checker u_checker (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      rsp_ch.ready = 0;
      forever begin
         if (hold_off) begin
            rsp_ch.ready <= 0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end else if (no_idle || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   task automatic send_event(logic [2:0] kind, logic [4:0] pid, logic [15:0] units,
                             logic [2:0] nst);
      req_ch.valid <= 1;
      req_ch.kind <= kind;
      req_ch.pid <= pid;
      req_ch.now <= clock_now;
      req_ch.sleep_units <= units;
      req_ch.new_status <= nst;
      do @(posedge clock); while (!req_ch.ready);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] reg_index, logic [31:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic advance_clock();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) clock_now = {$urandom, $urandom};
      else if (r < 5) clock_now = {48'hFFFF_FFFF_FFFF, 16'($urandom)};
      else clock_now += $urandom_range(0, 2500);
   endtask

   task automatic random_event();
      int r;
      logic [4:0] p;
      advance_clock();
      r = $urandom_range(0, 99);
      p = 5'($urandom_range(1, NPROC));
      if (r < 15) send_event(KIND_ARRIVE, p, 16'($urandom), 3'($urandom));
      else if (r < 55) send_event(KIND_YIELD, 5'($urandom), 16'($urandom), 3'($urandom));
      else if (r < 63)
         send_event(KIND_SLEEP, p, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 4)),
                    3'($urandom));
      else if (r < 73) send_event(KIND_SETST, p, 16'($urandom), 3'($urandom_range(0, 5)));
      else if (r < 85) begin
         send_event(KIND_SETST, p, 16'($urandom), ST_UNUSED);
         advance_clock();
         send_event(KIND_STOP, p, 16'($urandom), 3'($urandom));
      end else if (r < 89) send_event(KIND_STOP, p, 16'($urandom), 3'($urandom));
      else if (r < 93)
         send_event(3'($urandom_range(KIND_ARRIVE, KIND_SETST)),
                    ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(NPROC + 1, 31)),
                    16'($urandom), 3'($urandom));
      else if (r < 96)
         send_event(3'($urandom_range(KIND_SETST + 1, KIND_LAST)), 5'($urandom),
                    16'($urandom), 3'($urandom));
      else send_event(KIND_SETST, p, 16'($urandom), 3'($urandom_range(ST_WAITING + 1, ST_LAST)));
   endtask

   initial begin
      int limit;
      reset = 1;
      no_idle = 0;
      hold_off = 0;
      clock_now = 0;
      req_ch.valid = 0;
      req_ch.kind = KIND_ARRIVE;
      req_ch.pid = 0;
      req_ch.now = 0;
      req_ch.sleep_units = 0;
      req_ch.new_status = ST_UNUSED;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      clock_now = 64'd100;
      send_event(KIND_ARRIVE, 5'd1, 16'd0, ST_UNUSED);
      send_event(KIND_YIELD, 5'd0, 16'd0, ST_UNUSED);
      send_event(KIND_ARRIVE, 5'd2, 16'd0, ST_UNUSED);
      send_event(KIND_ARRIVE, 5'd16, 16'd0, ST_UNUSED);
      clock_now = 64'd1500;
      send_event(KIND_YIELD, 5'd31, 16'hFFFF, ST_LAST);
      send_event(KIND_SLEEP, 5'd1, 16'd0, ST_UNUSED);
      send_event(KIND_SLEEP, 5'd16, 16'hFFFF, ST_UNUSED);
      send_event(KIND_YIELD, 5'd0, 16'd0, ST_UNUSED);
      send_event(KIND_SLEEP, 5'd2, 16'd2, ST_UNUSED);
      clock_now = 64'd2800;
      send_event(KIND_YIELD, 5'd0, 16'd0, ST_UNUSED);
      send_event(KIND_YIELD, 5'd0, 16'd0, ST_UNUSED);
      clock_now = 64'hFFFF_FFFF_FFFF_FF00;
      send_event(KIND_SLEEP, 5'd3, 16'hFFFF, ST_UNUSED);
      send_event(KIND_SETST, 5'd2, 16'd0, ST_WAITING);
      send_event(KIND_SETST, 5'd2, 16'd0, ST_LAST);
      send_event(KIND_ARRIVE, 5'd0, 16'd0, ST_UNUSED);
      send_event(KIND_STOP, 5'd31, 16'd0, ST_UNUSED);
      send_event(KIND_LAST, 5'd1, 16'd0, ST_UNUSED);
      send_event(KIND_STOP, 5'd2, 16'd0, ST_UNUSED);
      send_event(KIND_SETST, 5'd2, 16'd0, ST_UNUSED);
      clock_now = 64'd50;
      send_event(KIND_STOP, 5'd2, 16'd0, ST_UNUSED);
      send_event(KIND_YIELD, 5'd0, 16'd0, ST_UNUSED);
      send_event(KIND_SETST, 5'd1, 16'd0, ST_UNUSED);
      send_event(KIND_YIELD, 5'd0, 16'd0, ST_UNUSED);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: ;
            1: begin
               csr_write(REG_QUANTUM, 32'd1);
               csr_write(REG_SYSPID, 32'd1);
               csr_write(REG_MIDQ, 32'd255);
               csr_write(REG_LOWQ, 32'd255);
            end
            2: begin
               csr_write(REG_QUANTUM, 32'hFFFF_FFFF);
               csr_write(REG_SYSPID, 32'd16);
               csr_write(REG_MIDQ, 32'd1);
               csr_write(REG_LOWQ, 32'd1);
            end
            3: begin
               csr_write(REG_QUANTUM, 32'd300);
               csr_write(REG_SYSPID, 32'd2);
               csr_write(REG_MIDQ, 32'd2);
               csr_write(REG_LOWQ, 32'd6);
            end
            default: begin
               csr_write(REG_QUANTUM, $urandom_range(1, 2000));
               csr_write(REG_SYSPID, $urandom_range(1, 16));
               csr_write(REG_MIDQ, $urandom_range(1, 4));
               csr_write(REG_LOWQ, $urandom_range(1, 10));
            end
         endcase
         if (phase == 5) no_idle = 1;
         for (int n = 0; n < 245; n++) begin
            if (phase == 1 && n == 40) hold_off = 1;
            random_event();
         end
         drain();
      end

      limit = 0;
      while (pending != 0 && limit < 10000) begin
         @(posedge clock);
         limit++;
      end
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
